### rtl/msb_pkg.sv
// ----------------------------------------------------------------------------
// msb_pkg
// Shared defaults for the median select bisection unit.
// ----------------------------------------------------------------------------
package msb_pkg;

	localparam int unsigned MAX_SAMPLES_DEF = 4096;
	localparam int unsigned SAMPLE_BITS_DEF = 32;

endpackage

### rtl/msb_if.sv
// ----------------------------------------------------------------------------
// msb_in_if / msb_out_if
// Valid/ready channels for sample loading and median results.
// ----------------------------------------------------------------------------
interface msb_in_if #(
	parameter int unsigned SAMPLE_BITS = msb_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          last;

	modport source (output valid, output sample, output last, input ready);
	modport sink (input valid, input sample, input last, output ready);
endinterface

interface msb_out_if #(
	parameter int unsigned SAMPLE_BITS = msb_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] median;

	modport source (output valid, output median, input ready);
	modport sink (input valid, input median, output ready);
endinterface

### rtl/msb_sample_ram.sv
// ----------------------------------------------------------------------------
// msb_sample_ram
// Simple dual-port sample store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module msb_sample_ram #(
	parameter int unsigned DEPTH = msb_pkg::MAX_SAMPLES_DEF,
	parameter int unsigned WIDTH = msb_pkg::SAMPLE_BITS_DEF,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/median_select_bisection_unit.sv
// ----------------------------------------------------------------------------
// median_select_bisection_unit
// Loads a sample set, then finds its lower median by bisecting the value
// range with full counting passes over the sample store.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                         | note
//  ---------+-----+---------------------------------+---------------------------
//  load     | in  | sample[SAMPLE_BITS], last       | last starts selection
//  result   | out | median[SAMPLE_BITS]             | one transfer per set
//
//  Loading takes one sample per cycle; the store write port sets that rate.
//  Selection after last: a min/max pass over the store, then bisection
//  passes, each a trial setup, a read of all n samples and a check, with
//  at most about SAMPLE_BITS+1 passes; all share the single store read port.
//  load.ready is low during selection; loading resumes while a result waits.
//  Reset clears the sample count and control; the store needs no clearing.
// ----------------------------------------------------------------------------
module median_select_bisection_unit #(
	parameter int unsigned MAX_SAMPLES = msb_pkg::MAX_SAMPLES_DEF,
	parameter int unsigned SAMPLE_BITS = msb_pkg::SAMPLE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	msb_in_if.sink     load,
	msb_out_if.source  result
);

	localparam int unsigned AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
	localparam logic [SAMPLE_BITS-1:0] SIGN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SAMPLES);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MINMAX = 3'd1;
	localparam logic [2:0] ST_TRIAL  = 3'd2;
	localparam logic [2:0] ST_PASS   = 3'd3;
	localparam logic [2:0] ST_CHECK  = 3'd4;
	localparam logic [2:0] ST_EMIT   = 3'd5;

	logic [2:0]             state_q;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          rd_idx_q;
	logic                   v_s1;
	logic                   first_s1;
	logic                   last_s1;
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] out_data_q;

	logic [SAMPLE_BITS-1:0] lo_q, hi_q, trial_q, lb_q, sa_q, res_q;
	logic [CW-1:0]          below_q, above_q, equal_q;

	logic                   load_xfer;
	logic                   store_ok;
	logic                   rd_issue;
	logic [SAMPLE_BITS-1:0] rd_data_s1;
	logic [SAMPLE_BITS-1:0] ordered_in;
	logic [CW-1:0]          half;
	logic [CW:0]            below_equal;
	logic                   converged;
	logic                   emit_go;
	logic [SAMPLE_BITS-1:0] mid;

	assign load.ready    = (state_q == ST_IDLE);
	assign load_xfer     = load.valid && load.ready;
	assign store_ok      = (count_q < MAX_CNT);
	assign ordered_in    = load.sample ^ SIGN;
	assign rd_issue      = ((state_q == ST_MINMAX) || (state_q == ST_PASS))
	                       && (rd_idx_q < count_q);
	assign half          = (count_q >> 1) + CW'(count_q[0]);
	assign below_equal   = {1'b0, below_q} + {1'b0, equal_q};
	assign converged     = (below_q <= half) && (above_q <= half);
	assign emit_go       = (state_q == ST_EMIT) && (!out_valid_q || result.ready);
	// floor((a+b)/2) without a carry bit
	assign mid           = (lo_q >> 1) + (hi_q >> 1)
	                       + SAMPLE_BITS'(lo_q[0] & hi_q[0]);

	assign result.valid  = out_valid_q;
	assign result.median = out_data_q;

	msb_sample_ram #(
		.DEPTH (MAX_SAMPLES),
		.WIDTH (SAMPLE_BITS),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (load_xfer && store_ok),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (ordered_in),
		.rd_en   (rd_issue),
		.rd_addr (rd_idx_q[AW-1:0]),
		.rd_data (rd_data_s1)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_idx_q    <= '0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= rd_issue;
			if (rd_issue) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			// a new result may replace the one leaving in the same cycle
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (load_xfer) begin
						if (store_ok) begin
							count_q <= count_q + 1'b1;
						end
						if (load.last) begin
							rd_idx_q <= '0;
							state_q  <= ST_MINMAX;
						end
					end
				end
				ST_MINMAX: begin
					if (v_s1 && last_s1) begin
						state_q <= ST_TRIAL;
					end
				end
				ST_TRIAL: begin
					rd_idx_q <= '0;
					state_q  <= ST_PASS;
				end
				ST_PASS: begin
					if (v_s1 && last_s1) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= converged ? ST_EMIT : ST_TRIAL;
				end
				ST_EMIT: begin
					if (emit_go) begin
						count_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		first_s1 <= (rd_idx_q == '0);
		last_s1  <= (rd_idx_q == count_q - 1'b1);
		case (state_q)
			ST_MINMAX: begin
				if (v_s1) begin
					if (first_s1 || rd_data_s1 < lo_q) begin
						lo_q <= rd_data_s1;
					end
					if (first_s1 || rd_data_s1 > hi_q) begin
						hi_q <= rd_data_s1;
					end
				end
			end
			ST_TRIAL: begin
				trial_q <= mid;
				below_q <= '0;
				above_q <= '0;
				equal_q <= '0;
				lb_q    <= lo_q;
				sa_q    <= hi_q;
			end
			ST_PASS: begin
				if (v_s1) begin
					if (rd_data_s1 < trial_q) begin
						below_q <= below_q + 1'b1;
						if (rd_data_s1 > lb_q) begin
							lb_q <= rd_data_s1;
						end
					end else if (rd_data_s1 > trial_q) begin
						above_q <= above_q + 1'b1;
						if (rd_data_s1 < sa_q) begin
							sa_q <= rd_data_s1;
						end
					end else begin
						equal_q <= equal_q + 1'b1;
					end
				end
			end
			ST_CHECK: begin
				if (converged) begin
					if (below_q >= half) begin
						res_q <= lb_q;
					end else if (below_equal >= {1'b0, half}) begin
						res_q <= trial_q;
					end else begin
						res_q <= sa_q;
					end
				end else if (below_q > above_q) begin
					hi_q <= lb_q;
				end else begin
					lo_q <= sa_q;
				end
			end
			ST_EMIT: begin
				if (emit_go) begin
					out_data_q <= res_q ^ SIGN;
				end
			end
			default: begin
			end
		endcase
	end

	// assertions
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("sample count beyond store depth");

	a_read_state: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (state_q == ST_MINMAX || state_q == ST_PASS))
		else $error("read data returned outside a pass");

	a_pass_total: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> ({1'b0, below_q} + {1'b0, above_q}
		+ {1'b0, equal_q} == {1'b0, count_q}))
		else $error("pass counts do not cover the set");

	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(load_xfer && load.last) |=> (state_q == ST_MINMAX && !load.ready))
		else $error("last transfer did not start selection");

endmodule
